[sv/fconv_pkg.sv]
// ----------------------------------------------------------------------------
// fconv_pkg
// Widths, operation codes and shared types of the full-convolution FIR.
// ----------------------------------------------------------------------------
`default_nettype none

package fconv_pkg;

    localparam int SAMPLE_W   = 16;   // Q1.15 sample and coefficient
    localparam int TAP_IDX_W  = 4;
    localparam int CFG_W      = 5;
    localparam int PROD_W     = 32;   // Q2.30 product
    localparam int GROUP_SIZE = 4;    // products summed per first-level adder
    localparam int GROUP_W    = PROD_W + 2;
    localparam int SUM_W      = 36;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 40;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // control that travels beside each step through the pipeline
    typedef struct packed {
        logic valid;
        logic last;
    } step_t;

    function automatic logic signed [PROD_W-1:0] mul_q15(
        input logic [SAMPLE_W-1:0] a,
        input logic [SAMPLE_W-1:0] b
    );
        logic signed [PROD_W-1:0] ax;
        logic signed [PROD_W-1:0] bx;
        ax = PROD_W'(signed'(a));
        bx = PROD_W'(signed'(b));
        return ax * bx;
    endfunction

endpackage

`default_nettype wire

[sv/fconv_ctrl.sv]
// ----------------------------------------------------------------------------
// fconv_ctrl
// Tap store, sample history, tap-count register and tail flush sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

module fconv_ctrl #(
    parameter int MAX_TAPS = 16
) (
    input  wire logic                                         aclk,
    input  wire logic                                         aresetn,
    input  wire logic                                         advance,
    input  wire logic                                         s_tvalid,
    output logic                                              s_tready,
    input  wire logic [fconv_pkg::S_TDATA_W-1:0]              s_tdata,
    input  wire logic                                         s_tuser,
    input  wire logic                                         s_tlast,
    input  wire logic                                         cfg_wr_en,
    input  wire logic [fconv_pkg::CFG_W-1:0]                  cfg_wr_data,
    output logic [MAX_TAPS-1:0][fconv_pkg::SAMPLE_W-1:0]      window,
    output logic [MAX_TAPS-1:0][fconv_pkg::SAMPLE_W-1:0]      coef,
    output fconv_pkg::step_t                                  step
);

    localparam int HistDepth = (MAX_TAPS > 1) ? MAX_TAPS - 1 : 1;

    logic [fconv_pkg::CFG_W-1:0]    tap_count_reg;
    logic [fconv_pkg::CFG_W-1:0]    flush_cnt_reg;
    logic [fconv_pkg::SAMPLE_W-1:0] coef_reg [MAX_TAPS];
    logic [fconv_pkg::SAMPLE_W-1:0] hist_reg [HistDepth];

    logic [fconv_pkg::CFG_W-1:0]     taps_n;
    logic [fconv_pkg::TAP_IDX_W-1:0] tap_idx;
    logic [fconv_pkg::SAMPLE_W-1:0]  value;
    logic [fconv_pkg::SAMPLE_W-1:0]  cur;
    logic                            flush_active;
    logic                            accept;
    logic                            is_sample;
    logic                            is_load;

    assign tap_idx = s_tdata[fconv_pkg::TAP_IDX_W-1:0];
    assign value   = s_tdata[fconv_pkg::TAP_IDX_W +: fconv_pkg::SAMPLE_W];

    always_comb begin
        if (tap_count_reg == '0) begin
            taps_n = fconv_pkg::CFG_W'(1);
        end else if (int'(tap_count_reg) > MAX_TAPS) begin
            taps_n = fconv_pkg::CFG_W'(MAX_TAPS);
        end else begin
            taps_n = tap_count_reg;
        end
    end

    assign flush_active = (flush_cnt_reg != '0);
    assign s_tready     = advance && !flush_active;
    assign accept       = s_tvalid && s_tready;
    assign is_sample    = accept && (s_tuser == fconv_pkg::OP_SAMPLE);
    assign is_load      = accept && (s_tuser == fconv_pkg::OP_LOAD);

    // the tail feeds zeros in place of samples
    assign cur = flush_active ? '0 : value;

    always_comb begin
        step.valid = is_sample || (advance && flush_active);
        if (flush_active) begin
            step.last = (flush_cnt_reg == fconv_pkg::CFG_W'(1));
        end else begin
            step.last = s_tlast && (taps_n == fconv_pkg::CFG_W'(1));
        end
    end

    // taps beyond the count in use see a zero sample
    always_comb begin
        for (int k = 0; k < MAX_TAPS; k++) begin
            coef[k] = coef_reg[k];
            if (k >= int'(taps_n)) begin
                window[k] = '0;
            end else if (k == 0) begin
                window[k] = cur;
            end else begin
                window[k] = hist_reg[(k > 0) ? k - 1 : 0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_count_reg <= fconv_pkg::CFG_W'(1);
            flush_cnt_reg <= '0;
            for (int k = 0; k < MAX_TAPS; k++) begin
                coef_reg[k] <= '0;
            end
            for (int k = 0; k < HistDepth; k++) begin
                hist_reg[k] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                tap_count_reg <= cfg_wr_data;
            end
            for (int k = 0; k < MAX_TAPS; k++) begin
                if (is_load && (k == int'(tap_idx))) begin
                    coef_reg[k] <= value;
                end
            end
            if (is_sample && s_tlast && (taps_n != fconv_pkg::CFG_W'(1))) begin
                flush_cnt_reg <= taps_n - fconv_pkg::CFG_W'(1);
            end else if (advance && flush_active) begin
                flush_cnt_reg <= flush_cnt_reg - fconv_pkg::CFG_W'(1);
            end
            if (step.valid) begin
                if (step.last) begin
                    // sequence closed, history starts over from zero
                    for (int k = 0; k < HistDepth; k++) begin
                        hist_reg[k] <= '0;
                    end
                end else begin
                    for (int k = HistDepth - 1; k > 0; k--) begin
                        hist_reg[k] <= hist_reg[k-1];
                    end
                    hist_reg[0] <= cur;
                end
            end
        end
    end

endmodule

`default_nettype wire

[sv/fconv_mult.sv]
// ----------------------------------------------------------------------------
// fconv_mult
// One multiplier per tap into the product register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module fconv_mult #(
    parameter int MAX_TAPS = 16
) (
    input  wire logic                                         aclk,
    input  wire logic                                         aresetn,
    input  wire logic                                         advance,
    input  wire logic [MAX_TAPS-1:0][fconv_pkg::SAMPLE_W-1:0] window,
    input  wire logic [MAX_TAPS-1:0][fconv_pkg::SAMPLE_W-1:0] coef,
    input  wire fconv_pkg::step_t                             step_in,
    output logic [MAX_TAPS-1:0][fconv_pkg::PROD_W-1:0]        prod,
    output fconv_pkg::step_t                                  step_out
);

    logic [MAX_TAPS-1:0][fconv_pkg::PROD_W-1:0] prod_reg;
    fconv_pkg::step_t                           step_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
        end else if (advance) begin
            step_reg <= step_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int k = 0; k < MAX_TAPS; k++) begin
                prod_reg[k] <= fconv_pkg::mul_q15(window[k], coef[k]);
            end
        end
    end

    assign prod     = prod_reg;
    assign step_out = step_reg;

endmodule

`default_nettype wire

[sv/fconv_acc.sv]
// ----------------------------------------------------------------------------
// fconv_acc
// Two-level registered adder tree over the products, ending in the result
// register that drives the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module fconv_acc #(
    parameter int MAX_TAPS = 16
) (
    input  wire logic                                       aclk,
    input  wire logic                                       aresetn,
    input  wire logic                                       advance,
    input  wire logic [MAX_TAPS-1:0][fconv_pkg::PROD_W-1:0] prod,
    input  wire fconv_pkg::step_t                           step_in,
    output logic [fconv_pkg::SUM_W-1:0]                     sum,
    output fconv_pkg::step_t                                step_out
);

    localparam int NumGroups = (MAX_TAPS + fconv_pkg::GROUP_SIZE - 1) / fconv_pkg::GROUP_SIZE;

    logic [NumGroups-1:0][fconv_pkg::GROUP_W-1:0] group_reg;
    logic [NumGroups-1:0][fconv_pkg::GROUP_W-1:0] group_next;
    fconv_pkg::step_t                             group_step_reg;
    logic [fconv_pkg::SUM_W-1:0]                  sum_reg;
    logic [fconv_pkg::SUM_W-1:0]                  sum_next;
    fconv_pkg::step_t                             out_step_reg;

    always_comb begin
        for (int g = 0; g < NumGroups; g++) begin
            group_next[g] = '0;
            for (int j = 0; j < fconv_pkg::GROUP_SIZE; j++) begin
                if (g * fconv_pkg::GROUP_SIZE + j < MAX_TAPS) begin
                    group_next[g] = group_next[g] + fconv_pkg::GROUP_W'(signed'(
                        prod[g * fconv_pkg::GROUP_SIZE + j]));
                end
            end
        end
    end

    // wraps to the result width for very long filters
    always_comb begin
        sum_next = '0;
        for (int g = 0; g < NumGroups; g++) begin
            sum_next = sum_next + fconv_pkg::SUM_W'(signed'(group_reg[g]));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            group_step_reg <= '0;
            out_step_reg   <= '0;
        end else if (advance) begin
            group_step_reg <= step_in;
            out_step_reg   <= group_step_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            group_reg <= group_next;
            sum_reg   <= sum_next;
        end
    end

    assign sum      = sum_reg;
    assign step_out = out_step_reg;

endmodule

`default_nettype wire

[sv/fir_full_linear_convolution_top.sv]
// Pipeline: the product register takes a sample transfer, then the partial-sum
// and result registers carry it on to the output.
// Throughput: one item per cycle while the result is not waiting; a sample
// marked last holds off input while the tail outputs issue. The whole pipeline
// stalls together when the result waits.
// Reset clears taps and history to zero, tap_count to 1, and empties the pipe.
// ----------------------------------------------------------------------------
// fir_full_linear_convolution_top
// Direct-form FIR giving the full linear convolution of a sample sequence
// with a loaded tap set, including the tail after the last sample.
// ----------------------------------------------------------------------------
`default_nettype none

module fir_full_linear_convolution_top #(
    parameter int MAX_TAPS = 16   // 1 to 16
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [fconv_pkg::S_TDATA_W-1:0]    s_tdata,   // tap_index[3:0], value[19:4]
    input  wire logic                               s_tuser,   // op
    input  wire logic                               s_tlast,   // last_sample
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [fconv_pkg::M_TDATA_W-1:0]         m_tdata,   // sum[35:0]
    output logic                                    m_tlast,   // last
    input  wire logic                               cfg_wr_en,
    input  wire logic [fconv_pkg::CFG_W-1:0]        cfg_wr_data
);

    logic                                          advance;
    logic [MAX_TAPS-1:0][fconv_pkg::SAMPLE_W-1:0]  window;
    logic [MAX_TAPS-1:0][fconv_pkg::SAMPLE_W-1:0]  coef;
    logic [MAX_TAPS-1:0][fconv_pkg::PROD_W-1:0]    prod;
    fconv_pkg::step_t                              ctrl_step;
    fconv_pkg::step_t                              prod_step;
    fconv_pkg::step_t                              out_step;
    logic [fconv_pkg::SUM_W-1:0]                   sum;

    // every stage moves when the result register is free or being taken
    assign advance = !out_step.valid || m_tready;

    fconv_ctrl #(
        .MAX_TAPS (MAX_TAPS)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .window      (window),
        .coef        (coef),
        .step        (ctrl_step)
    );

    fconv_mult #(
        .MAX_TAPS (MAX_TAPS)
    ) u_mult (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .window   (window),
        .coef     (coef),
        .step_in  (ctrl_step),
        .prod     (prod),
        .step_out (prod_step)
    );

    fconv_acc #(
        .MAX_TAPS (MAX_TAPS)
    ) u_acc (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .prod     (prod),
        .step_in  (prod_step),
        .sum      (sum),
        .step_out (out_step)
    );

    assign m_tvalid = out_step.valid;
    assign m_tlast  = out_step.last;
    assign m_tdata  = fconv_pkg::M_TDATA_W'(sum);

endmodule

`default_nettype wire
